### design/lfwnp_pkg.sv
`timescale 1ns / 1ps

package lfwnp_pkg;

	localparam int MAG_W      = 47;
	localparam int MANT_W     = 48;
	localparam int FRAC_W     = 4;
	localparam int CHARS_W    = 4;
	localparam int LEN_OUT_W  = 6;
	localparam int CFG_W      = 7;

	localparam logic [MAG_W-1:0] MANT_LIMIT = MAG_W'(64'd99999999999999);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_TOKEN  = 2'd1;
	localparam logic [1:0] PH_FOUND  = 2'd2;

	localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

	typedef struct packed {
		logic [1:0]         phase;
		logic [CHARS_W-1:0] chars;
		logic [MAG_W-1:0]   mag;
		logic               neg;
		logic [1:0]         dots;
		logic [FRAC_W-1:0]  frac;
		logic               seen;
	} tok_t;

	typedef struct packed {
		logic advance;
		logic restart;
		logic scan;
		logic finish;
	} tok_ctrl_t;

	typedef struct packed {
		logic                     weight_valid;
		logic signed [MANT_W-1:0] weight_mantissa;
		logic [FRAC_W-1:0]        fraction_digits;
		logic [LEN_OUT_W-1:0]     frame_length;
	} result_t;

endpackage

### design/lfwnp_token.sv
`timescale 1ns / 1ps

module lfwnp_token import lfwnp_pkg::*; #(
	parameter int NUMBER_BUFFER = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tok_ctrl_t         ctrl,
	input  logic [7:0]        data_byte,
	output logic              num_valid,
	output logic signed [MANT_W-1:0] num_mantissa,
	output logic [FRAC_W-1:0] num_frac
);

	localparam logic [CHARS_W-1:0] CHARS_CAP = CHARS_W'(NUMBER_BUFFER - 1);

	tok_t tok_q;
	tok_t base;
	tok_t scanned;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Take one digit or dot into the token.
	function automatic tok_t take_char(input tok_t t, input logic [7:0] b);
		tok_t r;
		logic [MAG_W+3:0] wide;
		logic [MAG_W+3:0] sum;
		r = t;
		wide = {4'b0, t.mag};
		sum = (wide << 3) + (wide << 1) + (MAG_W+4)'(b - CH_ZERO);
		r.chars = t.chars + 1'b1;
		if (is_digit(b)) begin
			r.seen = 1'b1;
			if (t.dots < 2'd2) begin
				r.mag = (sum > (MAG_W+4)'(MANT_LIMIT)) ? MANT_LIMIT : sum[MAG_W-1:0];
				if (t.dots == 2'd1 && t.frac < FRAC_MAX) begin
					r.frac = t.frac + 1'b1;
				end
			end
		end else if (t.dots < 2'd2) begin
			r.dots = t.dots + 1'b1;
		end
		return r;
	endfunction

	function automatic tok_t scan_byte(input tok_t t, input logic [7:0] b);
		tok_t r;
		tok_t fresh;
		logic dig;
		logic handled;
		r = t;
		fresh = '0;
		dig = is_digit(b);
		handled = 1'b0;
		if (t.phase == PH_TOKEN) begin
			if (t.chars < CHARS_CAP && (dig || b == CH_DOT)) begin
				r = take_char(t, b);
				handled = 1'b1;
			end else if (t.seen) begin
				r.phase = PH_FOUND;
				handled = 1'b1;
			end else begin
				// sign with dots only: drop it and look at this byte again
				r = fresh;
			end
		end
		if (!handled && r.phase == PH_SEARCH) begin
			if (b == CH_PLUS || b == CH_MINUS) begin
				r = fresh;
				r.phase = PH_TOKEN;
				r.neg = (b == CH_MINUS);
				r.chars = CHARS_W'(1);
			end else if (dig) begin
				fresh.phase = PH_TOKEN;
				r = take_char(fresh, b);
			end
		end
		return r;
	endfunction

	assign base = ctrl.restart ? tok_t'('0) : tok_q;
	assign scanned = ctrl.scan ? scan_byte(base, data_byte) : base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (ctrl.advance) begin
			tok_q <= ctrl.finish ? tok_t'('0) : scanned;
		end
	end

	assign num_valid = (base.phase == PH_FOUND) || (base.phase == PH_TOKEN && base.seen);

	always_comb begin
		num_mantissa = '0;
		num_frac = '0;
		if (num_valid) begin
			num_mantissa = base.neg ? -$signed({1'b0, base.mag}) : $signed({1'b0, base.mag});
			num_frac = base.frac;
		end
	end

endmodule

### design/lfwnp_out_buf.sv
`timescale 1ns / 1ps

module lfwnp_out_buf import lfwnp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t data
);

	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign data = data_q;

endmodule

### design/line_framed_weight_number_parser.sv
`timescale 1ns / 1ps

// Channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | command, data_byte
// out      | out_valid / out_ready | weight_valid, weight_mantissa, fraction_digits,
//          |                       | frame_length
// cfg      | cfg_write_en          | cfg_write_data (max_frame_len)
//
// One transaction a cycle on the input while in_ready is high; a newline's result
// passes the input register, then the result register.
// The parse step into the token state is one saturating multiply-by-ten add.
// Reset clears the frame, the token state and max_frame_len to 64.
// A full result register with out_ready low holds a newline in the input register
// and the input behind it; bytes that give no result never wait on the output.

module line_framed_weight_number_parser import lfwnp_pkg::*; #(
	parameter int FRAME_BUFFER_BYTES = 64,
	parameter int NUMBER_BUFFER      = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic [7:0]               data_byte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     weight_valid,
	output logic signed [MANT_W-1:0] weight_mantissa,
	output logic [FRAC_W-1:0]        fraction_digits,
	output logic [LEN_OUT_W-1:0]     frame_length,
	input  logic                     cfg_write_en,
	input  logic [CFG_W-1:0]         cfg_write_data
);

	localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int LEN_W = (CNT_W > LEN_OUT_W) ? CNT_W : LEN_OUT_W;
	localparam logic [CNT_W-1:0] FRAME_FULL = CNT_W'(FRAME_BUFFER_BYTES);

	logic [CFG_W-1:0] max_frame_len_q;

	// input register
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] data_byte_s1;

	// frame state
	logic [CNT_W-1:0] byte_count_q;
	logic             last_ret_q;

	logic             is_data;
	logic             is_newline;
	logic             frame_full;
	logic [CNT_W-1:0] count_base;
	logic             ret_base;
	logic [LEN_W-1:0] len_wide;
	logic             buf_free;
	logic             advance;
	logic             load_result;
	tok_ctrl_t        tok_ctrl;
	logic             num_valid;
	logic signed [MANT_W-1:0] num_mantissa;
	logic [FRAC_W-1:0] num_frac;
	result_t          result;
	result_t          out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= CFG_W'(64);
		end else if (cfg_write_en) begin
			max_frame_len_q <= cfg_write_data;
		end
	end

	assign is_data    = !command_s1;
	assign is_newline = is_data && (data_byte_s1 == CH_LF);

	// Advance unless a newline result has nowhere to go.
	assign advance     = valid_s1 && (!is_newline || buf_free);
	assign load_result = advance && is_newline;
	assign in_ready    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1   <= command;
			data_byte_s1 <= data_byte;
		end
	end

	// A frame that filled the buffer with no newline is dropped before this byte.
	assign frame_full = byte_count_q >= FRAME_FULL;
	assign count_base = frame_full ? '0 : byte_count_q;
	assign ret_base   = frame_full ? 1'b0 : last_ret_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			last_ret_q   <= 1'b0;
		end else if (advance) begin
			if (!is_data || is_newline) begin
				byte_count_q <= '0;
				last_ret_q   <= 1'b0;
			end else begin
				byte_count_q <= count_base + 1'b1;
				last_ret_q   <= (data_byte_s1 == CH_CR);
			end
		end
	end

	always_comb begin
		tok_ctrl.advance = advance;
		tok_ctrl.restart = frame_full && is_data;
		tok_ctrl.scan    = is_data && !is_newline &&
			(CMP_W'(count_base) < CMP_W'(max_frame_len_q));
		tok_ctrl.finish  = !is_data || is_newline;
	end

	lfwnp_token #(
		.NUMBER_BUFFER (NUMBER_BUFFER)
	) u_token (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (tok_ctrl),
		.data_byte    (data_byte_s1),
		.num_valid    (num_valid),
		.num_mantissa (num_mantissa),
		.num_frac     (num_frac)
	);

	// Drop one trailing carriage return from the reported length.
	assign len_wide = LEN_W'(count_base) - LEN_W'(ret_base);

	always_comb begin
		result.weight_valid    = num_valid;
		result.weight_mantissa = num_mantissa;
		result.fraction_digits = num_frac;
		result.frame_length    = len_wide[LEN_OUT_W-1:0];
	end

	lfwnp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_result),
		.load_data (result),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data      (out_data)
	);

	assign weight_valid    = out_data.weight_valid;
	assign weight_mantissa = out_data.weight_mantissa;
	assign fraction_digits = out_data.fraction_digits;
	assign frame_length    = out_data.frame_length;

endmodule
